[rtl/multi_mode_task_scheduler_top_defines.svh]
// ----------------------------------------------------------------------------
// Multi-mode task scheduler assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef MULTI_MODE_TASK_SCHEDULER_TOP_DEFINES_SVH
`define MULTI_MODE_TASK_SCHEDULER_TOP_DEFINES_SVH

// same-cycle implication
`define MMTS_ASSERT_HOLDS(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MMTS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/mmts_pkg.sv]
// ----------------------------------------------------------------------------
// Multi-mode task scheduler package
// Sizes, codes, queue entry type and index helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package mmts_pkg;

    localparam int MAX_TASKS  = 16;
    localparam int ID_BITS    = 8;
    localparam int IDX_W      = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W      = $clog2(MAX_TASKS + 1);
    localparam int PRI_W      = 8;
    localparam int LEN_W      = 16;
    localparam int TICK_W     = 16;
    localparam int TPRI_W     = 7;
    localparam int OUT_ID_W   = 8;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam int S_DATA_W   = 24;
    localparam int S_USER_W   = 2;
    localparam int M_DATA_W   = 40;

    localparam logic [ID_BITS-1:0] ID_LIMIT     = '1;
    localparam logic [TICK_W-1:0]  TICK_MAX     = '1;
    localparam logic [PRI_W-1:0]   PRI_FLOOR    = {1'b1, {(PRI_W-1){1'b0}}};
    localparam logic [TICK_W-1:0]  QUANTUM_INIT = TICK_W'(10);

    typedef enum logic [1:0] {
        MODE_FCFS,
        MODE_SJF,
        MODE_RR,
        MODE_PRIO
    } mode_t;

    typedef enum logic [1:0] {
        REQ_CREATE,
        REQ_TICK,
        REQ_EXIT,
        REQ_NOP
    } req_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_MODE,
        CFG_QUANTUM
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_DISPATCH,
        ST_INSERT,
        ST_PRIO,
        ST_FIN_RD,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic [ID_BITS-1:0] id;
        logic [PRI_W-1:0]   pri;
        logic [LEN_W-1:0]   len;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] offs);
        logic [CNT_W:0] sum;
        sum = {{(CNT_W+1-IDX_W){1'b0}}, base} + {1'b0, offs};
        if (sum >= (CNT_W+1)'(MAX_TASKS)) begin
            sum = sum - (CNT_W+1)'(MAX_TASKS);
        end
        return sum[IDX_W-1:0];
    endfunction

    function automatic logic [OUT_ID_W-1:0] id_to_out(input logic [ID_BITS-1:0] id);
        logic [ID_BITS+OUT_ID_W-1:0] ext;
        ext = {{OUT_ID_W{1'b0}}, id};
        return ext[OUT_ID_W-1:0];
    endfunction

endpackage

`default_nettype wire

[rtl/mmts_ram.sv]
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mmts_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[rtl/multi_mode_task_scheduler_top.sv]
// ----------------------------------------------------------------------------
// Multi-mode task scheduler
// Ready queue in a circular RAM, walked by a small sequencer one entry a cycle.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one event word: tuser is the request kind, tdata the
//   job length and priority of a task to create. m_ channel returns one result
//   word per event. Mode and quantum are set on the cfg_ port; the user must
//   write them only while idle, as the block itself does not enforce it.
// Path from accept to result: START, DISPATCH, FIN_RD, FIN; a priority-mode
//   tick on a non-empty queue adds a PRIO walk, and a shortest-job or priority
//   create that is not rejected adds an INSERT walk, both after DISPATCH.
//   The queue RAM is walked one entry per cycle, read and write overlapped.
// Throughput: one event at a time; s_tready rises together with m_tvalid,
//   when the result is loaded.
// Reset: queue empty, ids restart at zero, mode FCFS, quantum 10, no result
//   pending. No clearing pass is needed.
// Stall: the result holds in the output register; the next event is still
//   accepted and runs, and waits at its end until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_mode_task_scheduler_top
    import mmts_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [15:0] job_length, [22:16] task_priority, [23] zero
    input  wire logic [S_DATA_W-1:0]   s_tdata,
    // [1:0] req_type
    input  wire logic [S_USER_W-1:0]   s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [7:0] running_id, [8] running_valid, [9] switched, [10] stopped,
    // [11] rejected, [19:12] new_id, [35:20] run_ticks, [39:36] zero
    output logic      [M_DATA_W-1:0]   m_tdata
);

    state_t              state_reg, state_next;
    mode_t               mode_reg, mode_next;
    logic [TICK_W-1:0]   quantum_reg, quantum_next;
    logic [IDX_W-1:0]    head_reg, head_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [ID_BITS-1:0]  next_id_reg, next_id_next;
    logic [TICK_W-1:0]   tick_reg, tick_next;
    req_t                req_reg, req_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [TPRI_W-1:0]   pri_reg, pri_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic                found_reg, found_next;
    entry_t              carry_reg, carry_next;
    logic [ID_BITS-1:0]  id_before_reg, id_before_next;
    logic                valid_before_reg, valid_before_next;
    logic                stopped_reg, stopped_next;
    logic                rejected_reg, rejected_next;
    logic [ID_BITS-1:0]  new_id_reg, new_id_next;
    logic                out_valid_reg, out_valid_next;
    logic [M_DATA_W-1:0] out_data_reg, out_data_next;

    logic               ram_wr_en;
    logic [IDX_W-1:0]   ram_wr_addr;
    entry_t             ram_wr_entry;
    logic [IDX_W-1:0]   ram_rd_addr;
    logic [ENTRY_W-1:0] ram_rd_data;
    entry_t             rd_entry;

    logic [TICK_W-1:0]  tick_inc;
    logic [PRI_W-1:0]   new_pri;
    logic               key_worse;
    logic               sw;
    logic               valid_after;
    logic [TICK_W-1:0]  tick_out;
    logic [OUT_ID_W-1:0] run_id;

    assign rd_entry = entry_t'(ram_rd_data);
    assign tick_inc = (tick_reg == TICK_MAX) ? tick_reg : tick_reg + TICK_W'(1);
    assign new_pri  = {{(PRI_W-TPRI_W){1'b0}}, pri_reg};
    assign key_worse = (mode_reg == MODE_SJF) ? (rd_entry.len > len_reg)
                                              : ($signed(rd_entry.pri) < $signed(new_pri));
    assign valid_after = (count_reg != '0);
    assign sw       = valid_after && (!valid_before_reg || (rd_entry.id != id_before_reg));
    assign tick_out = sw ? '0 : tick_reg;
    assign run_id   = valid_after ? id_to_out(rd_entry.id) : '0;

    mmts_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_TASKS)
    ) u_queue_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_entry),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_FCFS;
            quantum_reg   <= QUANTUM_INIT;
            head_reg      <= '0;
            count_reg     <= '0;
            next_id_reg   <= '0;
            tick_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            quantum_reg   <= quantum_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            next_id_reg   <= next_id_next;
            tick_reg      <= tick_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg          <= req_next;
        len_reg          <= len_next;
        pri_reg          <= pri_next;
        idx_reg          <= idx_next;
        found_reg        <= found_next;
        carry_reg        <= carry_next;
        id_before_reg    <= id_before_next;
        valid_before_reg <= valid_before_next;
        stopped_reg      <= stopped_next;
        rejected_reg     <= rejected_next;
        new_id_reg       <= new_id_next;
        out_data_reg     <= out_data_next;
    end

    always_comb begin
        state_next        = state_reg;
        mode_next         = mode_reg;
        quantum_next      = quantum_reg;
        head_next         = head_reg;
        count_next        = count_reg;
        next_id_next      = next_id_reg;
        tick_next         = tick_reg;
        req_next          = req_reg;
        len_next          = len_reg;
        pri_next          = pri_reg;
        idx_next          = idx_reg;
        found_next        = found_reg;
        carry_next        = carry_reg;
        id_before_next    = id_before_reg;
        valid_before_next = valid_before_reg;
        stopped_next      = stopped_reg;
        rejected_next     = rejected_reg;
        new_id_next       = new_id_reg;
        out_valid_next    = out_valid_reg;
        out_data_next     = out_data_reg;
        ram_wr_en         = 1'b0;
        ram_wr_addr       = head_reg;
        ram_wr_entry      = carry_reg;
        ram_rd_addr       = head_reg;

        if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_MODE:    mode_next    = mode_t'(cfg_wr_data[1:0]);
                CFG_QUANTUM: quantum_next = cfg_wr_data[TICK_W-1:0];
                default: ;
            endcase
        end

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    req_next   = req_t'(s_tuser[1:0]);
                    len_next   = s_tdata[LEN_W-1:0];
                    pri_next   = s_tdata[LEN_W+TPRI_W-1:LEN_W];
                    state_next = ST_START;
                end
            end
            ST_START: begin
                stopped_next      = 1'b0;
                rejected_next     = 1'b0;
                new_id_next       = '0;
                valid_before_next = (count_reg != '0);
                state_next        = ST_DISPATCH;
            end
            ST_DISPATCH: begin
                id_before_next = rd_entry.id;
                state_next     = ST_FIN_RD;
                case (req_reg)
                    REQ_CREATE: begin
                        if (count_reg == CNT_W'(MAX_TASKS) || next_id_reg == ID_LIMIT) begin
                            rejected_next = 1'b1;
                        end else begin
                            new_id_next  = next_id_reg;
                            next_id_next = next_id_reg + ID_BITS'(1);
                            carry_next   = '{id: next_id_reg, pri: new_pri, len: len_reg};
                            idx_next     = '0;
                            found_next   = 1'b0;
                            if (mode_reg == MODE_SJF || mode_reg == MODE_PRIO) begin
                                state_next = ST_INSERT;
                            end else begin
                                ram_wr_en    = 1'b1;
                                ram_wr_addr  = wrap_add(head_reg, count_reg);
                                ram_wr_entry = '{id: next_id_reg, pri: new_pri, len: len_reg};
                                count_next   = count_reg + CNT_W'(1);
                            end
                        end
                    end
                    REQ_TICK: begin
                        if (count_reg != '0) begin
                            case (mode_reg)
                                MODE_RR: begin
                                    if (tick_reg >= quantum_reg) begin
                                        ram_wr_en    = 1'b1;
                                        ram_wr_addr  = wrap_add(head_reg, count_reg);
                                        ram_wr_entry = rd_entry;
                                        head_next    = wrap_add(head_reg, CNT_W'(1));
                                        tick_next    = '0;
                                    end else begin
                                        tick_next = tick_inc;
                                    end
                                end
                                MODE_PRIO: begin
                                    tick_next      = tick_inc;
                                    carry_next     = rd_entry;
                                    carry_next.pri = (rd_entry.pri == PRI_FLOOR) ? rd_entry.pri
                                                   : rd_entry.pri - PRI_W'(1);
                                    idx_next       = CNT_W'(1);
                                    ram_rd_addr    = wrap_add(head_reg, CNT_W'(1));
                                    state_next     = ST_PRIO;
                                end
                                default: tick_next = tick_inc;
                            endcase
                        end
                    end
                    REQ_EXIT: begin
                        stopped_next = (count_reg <= CNT_W'(1));
                        if (count_reg != '0) begin
                            head_next  = wrap_add(head_reg, CNT_W'(1));
                            count_next = count_reg - CNT_W'(1);
                            tick_next  = '0;
                        end
                    end
                    REQ_NOP: ;
                    default: ;
                endcase
            end
            ST_INSERT: begin
                ram_wr_addr = wrap_add(head_reg, idx_reg);
                if (idx_reg == count_reg) begin
                    ram_wr_en  = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    state_next = ST_FIN_RD;
                end else begin
                    if (found_reg || key_worse) begin
                        ram_wr_en  = 1'b1;
                        carry_next = rd_entry;
                        found_next = 1'b1;
                    end
                    idx_next    = idx_reg + CNT_W'(1);
                    ram_rd_addr = wrap_add(head_reg, idx_reg + CNT_W'(1));
                end
            end
            ST_PRIO: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = wrap_add(head_reg, idx_reg - CNT_W'(1));
                if (idx_reg != count_reg && $signed(rd_entry.pri) > $signed(carry_reg.pri)) begin
                    ram_wr_entry = rd_entry;
                    idx_next     = idx_reg + CNT_W'(1);
                    ram_rd_addr  = wrap_add(head_reg, idx_reg + CNT_W'(1));
                end else begin
                    state_next = ST_FIN_RD;
                end
            end
            ST_FIN_RD: begin
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = {{(M_DATA_W-OUT_ID_W-TICK_W-OUT_ID_W-4){1'b0}},
                                      tick_out, id_to_out(new_id_reg), rejected_reg,
                                      stopped_reg, sw, valid_after, run_id};
                    tick_next      = tick_out;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

[rtl/mmts_checker.sv]
// ----------------------------------------------------------------------------
// Multi-mode task scheduler port checker
// Port-level properties of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multi_mode_task_scheduler_top_defines.svh"

module mmts_checker
    import mmts_pkg::*;
(
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_tvalid,
    input wire logic                s_tready,
    input wire logic                m_tvalid,
    input wire logic [M_DATA_W-1:0] m_tdata
);

    `MMTS_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready, "scheduler ready right after taking a word")
    `MMTS_ASSERT_HOLDS(a_empty_has_no_id, aclk, aresetn, m_tvalid && !m_tdata[8], m_tdata[7:0] == 8'd0 && !m_tdata[9], "empty queue reports a running task")
    `MMTS_ASSERT_HOLDS(a_stop_means_empty, aclk, aresetn, m_tvalid && m_tdata[10], !m_tdata[8], "stop reported with a running task")
    `MMTS_ASSERT_HOLDS(a_reject_no_id, aclk, aresetn, m_tvalid && m_tdata[11], m_tdata[19:12] == 8'd0, "rejected create carries an id")
    `MMTS_ASSERT_HOLDS(a_switch_clears_ticks, aclk, aresetn, m_tvalid && m_tdata[9], m_tdata[8] && m_tdata[35:20] == 16'd0, "switch without cleared tick count")

endmodule

bind multi_mode_task_scheduler_top mmts_checker u_mmts_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata)
);

`default_nettype wire
